### hw/rtl/tcw_pkg.sv
// Package for the text console writer.
// Holds request codes, control characters, cell constants and the sequencer state type.
// Depends on nothing.
package tcw_pkg;

  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PUT    = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

endpackage

### hw/rtl/text_console_writer.sv
// Top level of the text console writer: screen memory, cursor and request sequencer.
// Depends on tcw_pkg.
//
//   channel | direction | words
//   in_     | input     | req_type, char_code, cell_index
//   out_    | output    | cursor_position, cell_word, scrolled
//   cfg_    | input     | text_attribute
//
// A printable character or control code passes through S_PUT and a cell read through S_READ
// before S_DONE; a read beyond the screen or an unused request type goes straight to S_DONE.
// A scroll adds a row copy of (ROWS-1)*COLUMNS cells and a fill of the bottom row,
// and a clear fills all COLUMNS*ROWS cells, all paced by the single memory write port.
// After reset a clearing pass over all COLUMNS*ROWS cells runs before the first word is taken.
// A new word is taken while the previous result still waits in the output register.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [10:0]       in_cell_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_cursor_position,
  output logic [CELL_W-1:0] out_cell_word,
  output logic              out_scrolled,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_text_attribute
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(COLUMNS + 8);
  localparam int RW = $clog2(ROWS + 1);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [CHAR_W-1:0] char_r;
  logic [CELL_W-1:0] word_r, word_nxt;
  logic              scroll_r, scroll_nxt;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CELL_W-1:0] out_word_r;
  logic              out_scroll_r;

  logic              in_fire, out_load;
  logic [AW-1:0]     cur_lin;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [CW-1:0]     p_col;
  logic [RW-1:0]     p_row;
  logic              p_we;
  logic [AW-1:0]     p_addr;
  logic [CELL_W-1:0] p_data;
  logic              p_scroll;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign cur_lin   = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_word       = out_word_r;
  assign out_scrolled        = out_scroll_r;

  always_comb begin
    p_col  = col_r;
    p_row  = row_r;
    p_we   = 1'b0;
    p_addr = cur_lin;
    p_data = {attr_r, char_r};
    unique case (char_r)
      CH_NEWLINE: begin
        p_col = '0;
        p_row = row_r + RW'(1);
      end
      CH_RETURN: begin
        p_col = '0;
      end
      CH_TAB: begin
        p_col = (col_r + CW'(8)) & ~CW'(7);
      end
      CH_BACKSPACE: begin
        if (col_r != '0) begin
          p_col  = col_r - CW'(1);
          p_we   = 1'b1;
          p_addr = cur_lin - AW'(1);
          p_data = {attr_r, BLANK_CHAR};
        end
      end
      default: begin
        p_we  = 1'b1;
        p_col = col_r + CW'(1);
      end
    endcase
    if (int'(p_col) >= COLUMNS) begin
      p_col = '0;
      p_row = p_row + RW'(1);
    end
    p_scroll = (int'(p_row) >= ROWS);
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    word_nxt   = word_r;
    scroll_nxt = scroll_r;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = {attr_r, BLANK_CHAR};
    re         = 1'b0;
    raddr      = cnt_r + AW'(COLUMNS);
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          word_nxt   = '0;
          scroll_nxt = 1'b0;
          unique case (in_req_type)
            REQ_PUT: begin
              state_nxt = S_PUT;
            end
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = S_FILL;
            end
            REQ_READ: begin
              if (int'(in_cell_index) < CELL_COUNT) begin
                re        = 1'b1;
                raddr     = AW'(in_cell_index);
                state_nxt = S_READ;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        we      = p_we;
        waddr   = p_addr;
        wdata   = p_data;
        col_nxt = p_col;
        if (p_scroll) begin
          row_nxt    = RW'(ROWS - 1);
          scroll_nxt = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_SCROLL;
        end else begin
          row_nxt   = p_row;
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        word_nxt  = rdata_r;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        re      = (cnt_r != AW'(MOVE_COUNT));
        we      = (cnt_r != '0);
        waddr   = cnt_r - AW'(1);
        wdata   = rdata_r;
        if (cnt_r == AW'(MOVE_COUNT)) begin
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_FILL: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    scroll_r <= scroll_nxt;
    if (in_fire) begin
      char_r <= in_char_code;
    end
    if (out_load) begin
      out_pos_r    <= POS_W'(cur_lin);
      out_word_r   <= word_r;
      out_scroll_r <= scroll_r;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (int'(col_r) < COLUMNS && int'(row_r) < ROWS))
    else $error("cursor outside the screen while idle");

  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (int'(row_r) == ROWS - 1 && scroll_r))
    else $error("scroll without cursor on the bottom row");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (int'(waddr) < CELL_COUNT))
    else $error("memory write beyond the screen");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("memory read and write hit the same cell");

endmodule

### verif/text_console_checker.sv
// Scoreboard for the text console writer: mirrors the screen store, cursor and attribute,
// predicts one result word per accepted request and compares it with the output channel.
// Depends on tcw_pkg.
module text_console_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [10:0]       in_cell_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [POS_W-1:0]  out_cursor_position,
  input  logic [CELL_W-1:0] out_cell_word,
  input  logic              out_scrolled,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_text_attribute,
  output int                mismatch_count,
  output int                pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } console_word_t;

  logic [CELL_W-1:0] screen [CELLS];
  logic [6:0]        column;
  logic [4:0]        row;
  logic [ATTR_W-1:0] attribute;
  console_word_t     awaited_words [$];

  function automatic logic [CELL_W-1:0] blank_cell_word();
    return {attribute, BLANK_CHAR};
  endfunction

  function automatic void blank_screen();
    for (int k = 0; k < CELLS; k++) begin
      screen[k] = blank_cell_word();
    end
  endfunction

  function automatic logic [POS_W-1:0] cursor_cell();
    return POS_W'(int'(row) * COLUMNS + int'(column));
  endfunction

  function automatic logic write_character(input logic [CHAR_W-1:0] ch);
    logic rolled;
    rolled = 1'b0;
    case (ch)
      CH_NEWLINE: begin
        column = '0;
        row = row + 5'd1;
      end
      CH_RETURN: begin
        column = '0;
      end
      CH_TAB: begin
        column = (column + 7'd8) & ~7'd7;
      end
      CH_BACKSPACE: begin
        if (column != 0) begin
          column = column - 7'd1;
          screen[cursor_cell()] = blank_cell_word();
        end
      end
      default: begin
        screen[cursor_cell()] = {attribute, ch};
        column = column + 7'd1;
      end
    endcase
    if (column >= COLUMNS) begin
      column = '0;
      row = row + 5'd1;
    end
    if (row >= ROWS) begin
      for (int k = 0; k < (ROWS - 1) * COLUMNS; k++) begin
        screen[k] = screen[k + COLUMNS];
      end
      for (int k = (ROWS - 1) * COLUMNS; k < CELLS; k++) begin
        screen[k] = blank_cell_word();
      end
      row = 5'(ROWS - 1);
      rolled = 1'b1;
    end
    return rolled;
  endfunction

  function automatic console_word_t predict_word(input logic [1:0] req,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [10:0] idx);
    console_word_t w;
    w = '0;
    case (req)
      REQ_PUT: begin
        w.scrolled = write_character(ch);
      end
      REQ_CLEAR: begin
        blank_screen();
        column = '0;
        row = '0;
      end
      REQ_READ: begin
        if (idx < CELLS) begin
          w.cell_value = screen[idx];
        end
      end
      default: begin
      end
    endcase
    w.position = cursor_cell();
    return w;
  endfunction

  always @(posedge clk) begin
    console_word_t want;
    if (!rst_n) begin
      attribute = RESET_ATTR;
      blank_screen();
      column = '0;
      row = '0;
      awaited_words.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attribute = cfg_text_attribute;
      end
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result word with none expected: position %0d cell %h scrolled %0b",
                   $time, out_cursor_position, out_cell_word, out_scrolled);
          mismatch_count++;
        end else begin
          want = awaited_words.pop_front();
          if (out_cursor_position !== want.position) begin
            $display("%0t: cursor position expected %0d, got %0d",
                     $time, want.position, out_cursor_position);
            mismatch_count++;
          end
          if (out_cell_word !== want.cell_value) begin
            $display("%0t: cell word expected %h, got %h", $time, want.cell_value,
                     out_cell_word);
            mismatch_count++;
          end
          if (out_scrolled !== want.scrolled) begin
            $display("%0t: scrolled expected %0b, got %0b", $time, want.scrolled, out_scrolled);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_words.push_back(predict_word(in_req_type, in_char_code, in_cell_index));
      end
    end
    pending_words = awaited_words.size();
  end

endmodule

### verif/testbench.sv
// Top of the text console writer testbench: clock, reset, request and attribute stimulus,
// output back-pressure, watchdog and verdict.
// Depends on tcw_pkg, text_console_checker and text_console_writer.
module testbench;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 238;

  bit clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic [CHAR_W-1:0] in_char_code;
  logic [10:0] in_cell_index;
  logic out_valid;
  logic out_ready;
  logic [POS_W-1:0] out_cursor_position;
  logic [CELL_W-1:0] out_cell_word;
  logic out_scrolled;
  logic cfg_valid;
  logic cfg_ready;
  logic [ATTR_W-1:0] cfg_text_attribute;
  int mismatch_count;
  int pending_words;
  int stuck_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_char_code(in_char_code),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cursor_position(out_cursor_position),
    .out_cell_word(out_cell_word),
    .out_scrolled(out_scrolled),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_text_attribute(cfg_text_attribute)
  );

  text_console_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_char_code(in_char_code),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cursor_position(out_cursor_position),
    .out_cell_word(out_cell_word),
    .out_scrolled(out_scrolled),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_text_attribute(cfg_text_attribute),
    .mismatch_count(mismatch_count),
    .pending_words(pending_words)
  );

  task automatic send_word(input logic [1:0] req, input logic [CHAR_W-1:0] ch,
                           input logic [10:0] idx);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_char_code <= ch;
    in_cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_text_attribute <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int hold_at);
    int n;
    int pick;
    int sel;
    logic [1:0] req;
    logic [CHAR_W-1:0] ch;
    logic [10:0] idx;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if (n == hold_at) begin
        rx_hold_pending = 1'b1;
      end
      ch = CHAR_W'($urandom);
      idx = 11'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        req = REQ_CLEAR;
      end else if (pick < 4) begin
        req = REQ_UNUSED;
      end else if (pick < 22) begin
        req = REQ_READ;
        if ($urandom_range(0, 9) != 0) begin
          idx = 11'($urandom_range(0, CELLS - 1));
        end
      end else begin
        req = REQ_PUT;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          ch = CH_NEWLINE;
        end else if (sel < 8) begin
          ch = CH_RETURN;
        end else if (sel < 12) begin
          ch = CH_TAB;
        end else if (sel < 18) begin
          ch = CH_BACKSPACE;
        end else if (sel >= 23) begin
          ch = CHAR_W'($urandom_range(32, 126));
        end
      end
      send_word(req, ch, idx);
    end
  endtask

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
          || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [6];
    logic [ATTR_W-1:0] value;
    int hold_at;
    phase_attr = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h7F};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_PUT;
    in_char_code = '0;
    in_cell_index = '0;
    cfg_valid = 1'b0;
    cfg_text_attribute = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_pending = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(REQ_READ, 8'h00, 11'd0);
    send_word(REQ_PUT, 8'h41, 11'($urandom));
    send_word(REQ_PUT, 8'h00, 11'($urandom));
    send_word(REQ_PUT, 8'hFF, 11'($urandom));
    send_word(REQ_PUT, 8'h7F, 11'($urandom));
    send_word(REQ_PUT, CH_TAB, 11'($urandom));
    send_word(REQ_PUT, CH_BACKSPACE, 11'($urandom));
    send_word(REQ_PUT, CH_RETURN, 11'($urandom));
    send_word(REQ_PUT, CH_BACKSPACE, 11'($urandom));
    send_word(REQ_PUT, CH_NEWLINE, 11'($urandom));
    repeat (10) send_word(REQ_PUT, CH_TAB, 11'($urandom));
    send_word(REQ_READ, 8'hFF, 11'h7FF);
    send_word(REQ_READ, 8'h00, 11'(CELLS - 1));
    send_word(REQ_READ, 8'h00, 11'(CELLS));
    send_word(REQ_UNUSED, 8'hFF, 11'h7FF);
    send_word(REQ_CLEAR, 8'h00, 11'd0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      value = (p == 2 || p == 4) ? ATTR_W'($urandom) : phase_attr[p];
      write_attribute(value);
      hold_at = (p == 1) ? 100 : ((p == 4) ? 60 : -1);
      run_random(PHASE_WORDS, hold_at);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
